// ===== rtl/symmetric_five_tap_fir_clamped_assert.svh =====
// Assertion macros for the filter block
`ifndef SYMMETRIC_FIVE_TAP_FIR_CLAMPED_ASSERT_SVH
`define SYMMETRIC_FIVE_TAP_FIR_CLAMPED_ASSERT_SVH

`ifndef SYNTH
`define SFIR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define SFIR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFIR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define SFIR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/sfir_pkg.sv =====
`default_nettype none
package sfir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 18;
  localparam int FRAC_SHIFT = 14;
  localparam int NUM_CELLS  = 4;
  localparam int NUM_WIN    = NUM_CELLS + 1;
  localparam int NUM_COEF   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
  localparam int INFL_W     = 2;
  localparam int PAIR_W     = SAMPLE_W + 1;
  localparam int PROD_W     = PAIR_W + COEF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int Q_W        = ACC_W - FRAC_SHIFT;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER = 2'd0,
    CFG_NEAR   = 2'd1,
    CFG_FAR    = 2'd2
  } cfg_reg_t;

  localparam coef_t COEF_CENTER_RST = 18'sd16384;
  localparam coef_t COEF_ZERO_RST   = 18'sd0;

  typedef struct packed {
    logic emit;
    logic last;
  } step_tag_t;

  typedef struct packed {
    sample_t value;
    logic    last;
  } result_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  full;
  } fifo_stat_t;

endpackage
`default_nettype wire

// ===== rtl/sfir_stream_if.sv =====
`default_nettype none
interface sfir_in_if;
  import sfir_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    line_end;
  modport source(output valid, output sample, output line_end, input ready);
  modport sink(input valid, input sample, input line_end, output ready);
endinterface

interface sfir_out_if;
  import sfir_pkg::*;
  logic    valid;
  logic    ready;
  sample_t value;
  logic    out_last;
  modport source(output valid, output value, output out_last, input ready);
  modport sink(input valid, input value, input out_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/symmetric_five_tap_fir_clamped.sv =====
// Channel  Dir  Handshake      Payload
// in_if    in   valid/ready    sample[15:0] signed, line_end
// out_if   out  valid/ready    value[15:0] signed, out_last
// cfg_     in   cfg_we         cfg_index[1:0], cfg_wdata[17:0]
//
// One input word per cycle while queue credit allows; a word with line_end
// holds the input while the flush steps run through the cell chain.
// A step's result passes through three MAC stages, then the output queue.
// An 8-entry output queue with credit count keeps input flowing while
// out_if stalls; input stops when queue plus MAC stages are full or in a flush.
// rst_n is synchronous; no clearing pass after reset.
`default_nettype none
`include "symmetric_five_tap_fir_clamped_assert.svh"
module symmetric_five_tap_fir_clamped (
  input  logic                               clk,
  input  logic                               rst_n,
  sfir_in_if.sink                            in_if,
  sfir_out_if.source                         out_if,
  input  logic                               cfg_we,
  input  logic [sfir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  sfir_pkg::coef_t                    cfg_wdata
);
  import sfir_pkg::*;

  coef_t                 coef_r [NUM_COEF];
  logic [1:0]            seen_r;
  logic                  busy_r;
  logic [1:0]            k_r;
  logic [1:0]            back_r;
  sample_t               x_r;

  fifo_stat_t            fifo_stat;
  logic [INFL_W-1:0]     inflight;
  logic [FIFO_CNT_W-1:0] occ;
  logic                  credit_ok;
  logic                  accept;
  logic                  step_go;
  logic                  step_load;
  sample_t               step_x;
  step_tag_t             tag;
  sample_t               tap [NUM_CELLS];
  sample_t               win [NUM_WIN];
  logic                  mac_push;
  result_t               mac_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[CFG_CENTER] <= COEF_CENTER_RST;
      coef_r[CFG_NEAR]   <= COEF_ZERO_RST;
      coef_r[CFG_FAR]    <= COEF_ZERO_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CENTER: coef_r[CFG_CENTER] <= cfg_wdata;
        CFG_NEAR:   coef_r[CFG_NEAR]   <= cfg_wdata;
        CFG_FAR:    coef_r[CFG_FAR]    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign occ       = fifo_stat.count + FIFO_CNT_W'(inflight);
  assign credit_ok = (occ < FIFO_CNT_W'(FIFO_DEPTH));
  assign in_if.ready = !busy_r && credit_ok;
  assign accept    = in_if.valid && in_if.ready;
  assign step_go   = busy_r ? credit_ok : accept;
  assign step_load = accept && (seen_r == 2'd0);
  assign step_x    = busy_r ? x_r : in_if.sample;

  // flush steps repeat the last word, which clamps the right edge
  always_comb begin
    if (busy_r) begin
      tag.emit = ({1'b0, k_r} + {1'b0, back_r}) >= 3'd2;
      tag.last = (k_r == 2'd2);
    end else begin
      tag.emit = (seen_r == 2'd2);
      tag.last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      busy_r <= 1'b0;
      k_r    <= '0;
      back_r <= '0;
    end else begin
      if (accept) begin
        if (in_if.line_end) begin
          busy_r <= 1'b1;
          k_r    <= 2'd1;
          back_r <= seen_r;
          seen_r <= '0;
        end else if (seen_r != 2'd2) begin
          seen_r <= seen_r + 1'b1;
        end
      end
      if (busy_r && credit_ok) begin
        if (k_r == 2'd2) begin
          busy_r <= 1'b0;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_if.sample;
    end
  end

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      sfir_cell u_cell (
        .clk      (clk),
        .shift_en (step_go),
        .load     (step_load),
        .x_i      (step_x),
        .left_i   (step_x),
        .tap_o    (tap[i])
      );
    end else begin : g_body
      sfir_cell u_cell (
        .clk      (clk),
        .shift_en (step_go),
        .load     (step_load),
        .x_i      (step_x),
        .left_i   (tap[i-1]),
        .tap_o    (tap[i])
      );
    end
    assign win[NUM_CELLS-1-i] = tap[i];
  end
  assign win[NUM_CELLS] = step_x;

  sfir_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_go    (step_go),
    .tag_i      (tag),
    .win_i      (win),
    .coef_i     (coef_r),
    .push_o     (mac_push),
    .res_o      (mac_res),
    .inflight_o (inflight)
  );

  sfir_ofifo u_ofifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (mac_push),
    .wdata_i (mac_res),
    .out_if  (out_if),
    .stat_o  (fifo_stat)
  );

  `SFIR_ASSERT_IMPL(a_no_overflow, clk, rst_n, mac_push, !fifo_stat.full, "queue overflow")
  `SFIR_ASSERT_NEXT(a_end_flush, clk, rst_n, accept && in_if.line_end, busy_r && (k_r == 2'd1), "flush not started")
  `SFIR_ASSERT_IMPL(a_last_emits, clk, rst_n, step_go && tag.last, tag.emit, "last step without word")
  `SFIR_ASSERT_NEXT(a_flush_done, clk, rst_n, busy_r && credit_ok && (k_r == 2'd2), !busy_r, "flush overrun")

endmodule
`default_nettype wire

// ===== rtl/sfir_cell.sv =====
`default_nettype none
module sfir_cell (
  input  logic             clk,
  input  logic             shift_en,
  input  logic             load,
  input  sfir_pkg::sample_t x_i,
  input  sfir_pkg::sample_t left_i,
  output sfir_pkg::sample_t tap_o
);
  import sfir_pkg::*;

  sample_t q_r;
  sample_t q_nxt;

  // on the first word of a line every cell reads as that word
  assign tap_o = load ? x_i : q_r;
  assign q_nxt = shift_en ? left_i : q_r;

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/sfir_mac.sv =====
`default_nettype none
module sfir_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_go,
  input  sfir_pkg::step_tag_t          tag_i,
  input  sfir_pkg::sample_t            win_i [sfir_pkg::NUM_WIN],
  input  sfir_pkg::coef_t              coef_i [sfir_pkg::NUM_COEF],
  output logic                         push_o,
  output sfir_pkg::result_t            res_o,
  output logic [sfir_pkg::INFL_W-1:0]  inflight_o
);
  import sfir_pkg::*;

  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam acc_t RND = acc_t'(1) <<< (FRAC_SHIFT - 1);

  function automatic sample_t sat_q(input acc_t a);
    logic [Q_W-1:0] q;
    begin
      q = a[ACC_W-1:FRAC_SHIFT];
      if (&q[Q_W-1:SAMPLE_W-1] || ~|q[Q_W-1:SAMPLE_W-1]) begin
        sat_q = q[SAMPLE_W-1:0];
      end else if (q[Q_W-1]) begin
        sat_q = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
        sat_q = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
    end
  endfunction

  logic  v1_r, v2_r, v3_r;
  logic  last1_r, last2_r, last3_r;
  pair_t c1_r, n1_r, f1_r;
  prod_t pc2_r, pn2_r, pf2_r;
  acc_t  acc3_r;
  acc_t  acc_nxt;

  assign acc_nxt = acc_t'(pc2_r) + acc_t'(pn2_r) + acc_t'(pf2_r) + RND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= step_go && tag_i.emit;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // pre-add of the symmetric pairs, then products, then sum with rounding
  always_ff @(posedge clk) begin
    c1_r    <= pair_t'(win_i[2]);
    n1_r    <= pair_t'(win_i[1]) + pair_t'(win_i[3]);
    f1_r    <= pair_t'(win_i[0]) + pair_t'(win_i[4]);
    last1_r <= tag_i.last;
    pc2_r   <= prod_t'(c1_r) * prod_t'(coef_i[CFG_CENTER]);
    pn2_r   <= prod_t'(n1_r) * prod_t'(coef_i[CFG_NEAR]);
    pf2_r   <= prod_t'(f1_r) * prod_t'(coef_i[CFG_FAR]);
    last2_r <= last1_r;
    acc3_r  <= acc_nxt;
    last3_r <= last2_r;
  end

  assign push_o      = v3_r;
  assign res_o.value = sat_q(acc3_r);
  assign res_o.last  = last3_r;
  assign inflight_o  = INFL_W'({1'b0, v1_r}) + INFL_W'({1'b0, v2_r})
                     + INFL_W'({1'b0, v3_r});

endmodule
`default_nettype wire

// ===== rtl/sfir_ofifo.sv =====
`default_nettype none
module sfir_ofifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  sfir_pkg::result_t    wdata_i,
  sfir_out_if.source           out_if,
  output sfir_pkg::fifo_stat_t stat_o
);
  import sfir_pkg::*;

  result_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  pop;

  assign pop = out_if.valid && out_if.ready;

  always_comb begin
    count_nxt = count_r;
    if (push_i && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

  assign out_if.valid    = (count_r != '0);
  assign out_if.value    = mem_r[rd_ptr_r].value;
  assign out_if.out_last = mem_r[rd_ptr_r].last;
  assign stat_o.count    = count_r;
  assign stat_o.full     = (count_r == FIFO_CNT_W'(FIFO_DEPTH));

endmodule
`default_nettype wire
